/* rtl/core/vbmr_pkg.sv */
// Shared types and constants for the virtio block MMIO register core.
// Holds the register map, access codes and the result beat layout.
// No dependencies.
`default_nettype none

package vbmr_pkg;

    // Access kind carried in s_axis_tuser
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    // Access sizes in bytes
    localparam logic [3:0] ACCESS_WORD  = 4'd4;
    localparam logic [3:0] ACCESS_DWORD = 4'd8;

    // Fixed identity values
    localparam logic [31:0] BLK_MAGIC      = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE  = 32'd2;
    localparam logic [31:0] DEV_TYPE_BLOCK = 32'd2;
    localparam logic [31:0] DEV_VENDOR     = 32'h554d_4551;
    localparam logic [31:0] MAX_QUEUE_SIZE = 32'd8;

    localparam logic [31:0] STATUS_FEATURES_OK = 32'h0000_0008;

    // Register offsets within the window
    localparam logic [11:0] OFF_MAGIC      = 12'h000;
    localparam logic [11:0] OFF_VERSION    = 12'h004;
    localparam logic [11:0] OFF_DEV_TYPE   = 12'h008;
    localparam logic [11:0] OFF_VENDOR     = 12'h00c;
    localparam logic [11:0] OFF_FEATURES   = 12'h010;
    localparam logic [11:0] OFF_QUEUE_SEL  = 12'h030;
    localparam logic [11:0] OFF_QUEUE_MAX  = 12'h034;
    localparam logic [11:0] OFF_QUEUE_SIZE = 12'h038;
    localparam logic [11:0] OFF_QUEUE_RDY  = 12'h044;
    localparam logic [11:0] OFF_NOTIFY     = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK    = 12'h064;
    localparam logic [11:0] OFF_STATUS     = 12'h070;
    localparam logic [11:0] OFF_DESC_LO    = 12'h080;
    localparam logic [11:0] OFF_DESC_HI    = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO   = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI   = 12'h094;
    localparam logic [11:0] OFF_USED_LO    = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI    = 12'h0a4;

    // Config space
    localparam logic [11:0] OFF_CFG_BASE   = 12'h100;
    localparam logic [11:0] CFG_CAP_LO     = 12'h000;
    localparam logic [11:0] CFG_CAP_HI     = 12'h004;

    localparam int CAP_W      = 48;
    localparam int TDATA_IN_W = 48;

    // Result beat; last member sits in the lowest bits
    typedef struct packed {
        logic [63:0] used_base;
        logic [63:0] available_base;
        logic [63:0] descriptor_base;
        logic [31:0] queue_size;
        logic        engine_reset;
        logic        queue_kick;
        logic        interrupt_line;
        logic        access_fault;
        logic [63:0] read_data;
    } t_result;

    localparam int RESULT_W    = $bits(t_result);
    localparam int TDATA_OUT_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/core/vbmr_regs.sv */
// Register state and access decode for the virtio block MMIO core.
// Depends on vbmr_pkg; register state other than capacity advances only on an accepted access beat.
`default_nettype none

module vbmr_regs (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [47:0]            i_cfg_wr_data,
    input  wire logic                   i_accept,
    input  wire vbmr_pkg::t_opcode      i_opcode,
    input  wire logic [11:0]            i_reg_offset,
    input  wire logic [3:0]             i_access_bytes,
    input  wire logic [31:0]            i_write_data,
    output vbmr_pkg::t_result           o_result
);
    import vbmr_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic [31:0]      r_status,    n_status;
    logic [31:0]      r_qsize,     n_qsize;
    logic [31:0]      r_qready,    n_qready;
    logic [31:0]      r_irq_bits,  n_irq_bits;
    logic [63:0]      r_desc,      n_desc;
    logic [63:0]      r_avail,     n_avail;
    logic [63:0]      r_used,      n_used;
    logic             r_irq_line,  n_irq_line;

    logic [63:0] rd_data;
    logic        fault;
    logic        kick;
    logic        eng_rst;
    logic        size_ok;
    logic        is_cfg;
    logic [11:0] cfg_off;
    logic [31:0] acked_bits;

    assign size_ok    = (i_access_bytes == ACCESS_WORD);
    assign is_cfg     = (i_reg_offset >= OFF_CFG_BASE);
    assign cfg_off    = i_reg_offset - OFF_CFG_BASE;
    assign acked_bits = r_irq_bits & ~i_write_data;

    always_comb begin
        n_status   = r_status;
        n_qsize    = r_qsize;
        n_qready   = r_qready;
        n_irq_bits = r_irq_bits;
        n_desc     = r_desc;
        n_avail    = r_avail;
        n_used     = r_used;
        n_irq_line = r_irq_line;
        rd_data    = 64'd0;
        fault      = 1'b0;
        kick       = 1'b0;
        eng_rst    = 1'b0;

        if (i_opcode == OP_READ) begin
            if (is_cfg) begin
                // config space reads never fault
                if (cfg_off == CFG_CAP_LO && i_access_bytes == ACCESS_DWORD) begin
                    rd_data = {16'd0, r_capacity};
                end else if (cfg_off == CFG_CAP_LO && size_ok) begin
                    rd_data = {32'd0, r_capacity[31:0]};
                end else if (cfg_off == CFG_CAP_HI && size_ok) begin
                    rd_data = {48'd0, r_capacity[47:32]};
                end
            end else if (!size_ok) begin
                fault = 1'b1;
            end else begin
                unique case (i_reg_offset)
                    OFF_MAGIC:      rd_data = {32'd0, BLK_MAGIC};
                    OFF_VERSION:    rd_data = {32'd0, VERSION_VALUE};
                    OFF_DEV_TYPE:   rd_data = {32'd0, DEV_TYPE_BLOCK};
                    OFF_VENDOR:     rd_data = {32'd0, DEV_VENDOR};
                    OFF_FEATURES:   rd_data = 64'd0;
                    OFF_QUEUE_MAX:  rd_data = {32'd0, MAX_QUEUE_SIZE};
                    OFF_QUEUE_RDY:  rd_data = {32'd0, r_qready};
                    OFF_IRQ_STATUS: rd_data = {32'd0, r_irq_bits};
                    OFF_STATUS:     rd_data = {32'd0, r_status};
                    default:        rd_data = 64'd0;
                endcase
            end
        end else if (!size_ok) begin
            fault = 1'b1;
        end else begin
            unique case (i_reg_offset)
                OFF_QUEUE_SIZE: n_qsize  = i_write_data;
                OFF_QUEUE_RDY:  n_qready = i_write_data;
                OFF_DESC_LO:    n_desc   = {r_desc[63:32], i_write_data};
                OFF_DESC_HI:    n_desc   = {i_write_data, r_desc[31:0]};
                OFF_AVAIL_LO:   n_avail  = {r_avail[63:32], i_write_data};
                OFF_AVAIL_HI:   n_avail  = {i_write_data, r_avail[31:0]};
                OFF_USED_LO:    n_used   = {r_used[63:32], i_write_data};
                OFF_USED_HI:    n_used   = {i_write_data, r_used[31:0]};
                OFF_NOTIFY: begin
                    if (r_qsize != 32'd0) begin
                        kick       = 1'b1;
                        n_irq_bits = r_irq_bits | 32'd1;
                        n_irq_line = 1'b1;
                    end
                end
                OFF_IRQ_ACK: begin
                    n_irq_bits = acked_bits;
                    if (acked_bits == 32'd0) begin
                        n_irq_line = 1'b0;
                    end
                end
                OFF_STATUS: begin
                    n_status = i_write_data;
                    if (i_write_data == 32'd0) begin
                        // device reset; line kept until acked
                        n_qsize    = 32'd0;
                        n_qready   = 32'd0;
                        n_irq_bits = 32'd0;
                        n_desc     = 64'd0;
                        n_avail    = 64'd0;
                        n_used     = 64'd0;
                        eng_rst    = 1'b1;
                    end else if ((i_write_data & STATUS_FEATURES_OK) != 32'd0) begin
                        n_status = i_write_data | STATUS_FEATURES_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_status   <= '0;
            r_qsize    <= '0;
            r_qready   <= '0;
            r_irq_bits <= '0;
            r_desc     <= '0;
            r_avail    <= '0;
            r_used     <= '0;
            r_irq_line <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_status   <= n_status;
                r_qsize    <= n_qsize;
                r_qready   <= n_qready;
                r_irq_bits <= n_irq_bits;
                r_desc     <= n_desc;
                r_avail    <= n_avail;
                r_used     <= n_used;
                r_irq_line <= n_irq_line;
            end
        end
    end

    always_comb begin
        o_result.read_data       = rd_data;
        o_result.access_fault    = fault;
        o_result.interrupt_line  = n_irq_line;
        o_result.queue_kick      = kick;
        o_result.engine_reset    = eng_rst;
        o_result.queue_size      = n_qsize;
        o_result.descriptor_base = n_desc;
        o_result.available_base  = n_avail;
        o_result.used_base       = n_used;
    end

    // pending interrupt bits always come with the line raised
    a_bits_imply_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_irq_bits != 32'd0) |-> r_irq_line)
        else $error("irq status bits set with line low");

    a_kick_raises_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.queue_kick |-> (o_result.interrupt_line && r_qsize != 32'd0))
        else $error("kick without interrupt or queue size");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.engine_reset) |=>
            (r_qsize == 32'd0 && r_desc == 64'd0 && r_avail == 64'd0
             && r_used == 64'd0 && r_irq_bits == 32'd0))
        else $error("engine reset left queue state");

    a_fault_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.access_fault) |=>
            ($stable(r_status) && $stable(r_qsize) && $stable(r_irq_line)))
        else $error("faulting access changed state");

endmodule

`default_nettype wire

/* rtl/core/vbmr_out_buf.sv */
// Two-entry result buffer (output register plus skid stage).
// Depends on vbmr_pkg for the result beat type.
`default_nettype none

module vbmr_out_buf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire vbmr_pkg::t_result i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output vbmr_pkg::t_result  o_data
);
    import vbmr_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    stalled;
    logic    take;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign stalled = r_main_valid && !i_ready;
    assign take    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (stalled) begin
            if (take) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_main_valid <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stalled) begin
            if (take) begin
                r_skid <= i_data;
            end
        end else if (r_skid_valid) begin
            r_main <= r_skid;
        end else if (take) begin
            r_main <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid holds a beat with the output register empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_ready) |=> (r_main_valid && $stable(r_main)))
        else $error("stalled output beat changed");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (!r_skid_valid && r_main == $past(r_skid)))
        else $error("skid beat not moved to output");

endmodule

`default_nettype wire

/* rtl/core/virtio_block_mmio_registers_core.sv */
// Top level of the virtio block MMIO register core.
// Depends on vbmr_pkg, vbmr_regs and vbmr_out_buf.
//
// Usage:
//   s_axis carries one bus access per beat: tuser[0] is the access kind
//   (0 read, 1 write), tdata the offset, size and write data. m_axis returns
//   one result beat per access: read data, fault flag, interrupt level, the
//   kick and engine-reset pulses, and the queue size and ring bases as they
//   stand after the access.
//   Capacity (in 512-byte sectors) is loaded through i_cfg_wr_en /
//   i_cfg_wr_data while no access is in flight.
// Timing:
//   An access is decoded and applied in the cycle it is accepted; its result beat
//   is registered in the output register, or the skid stage on a stall. With
//   m_axis_tready high one beat per cycle is sustained; the buffer holds two beats.
// Stall:
//   With m_axis_tready low one further beat is taken into the skid stage,
//   then s_axis_tready drops until the output drains. State other than capacity moves
//   only on accepted beats, so stalls never alter results.
// Reset:
//   Synchronous, active low. All queue registers, ring bases, interrupt state
//   and capacity clear to zero; both buffer entries are emptied.
`default_nettype none

module virtio_block_mmio_registers_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration write
    input  wire logic          i_cfg_wr_en,
    input  wire logic [47:0]   i_cfg_wr_data,   // capacity_sectors
    // access beats in
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [47:0]   s_axis_tdata,    // reg_offset[11:0], access_bytes[15:12],
                                                // write_data[47:16]
    input  wire logic [0:0]    s_axis_tuser,    // opcode[0]
    // result beats out
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [295:0]       m_axis_tdata     // read_data[63:0], access_fault[64],
                                                // interrupt_line[65], queue_kick[66],
                                                // engine_reset[67], queue_size[99:68],
                                                // descriptor_base[163:100],
                                                // available_base[227:164],
                                                // used_base[291:228], zero pad
);
    import vbmr_pkg::*;

    logic    in_accept;
    t_result w_result;
    t_result w_out;

    // an access is taken whenever the buffer has room
    assign in_accept = s_axis_tvalid && s_axis_tready;

    vbmr_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_accept       (in_accept),
        .i_opcode       (t_opcode'(s_axis_tuser[0])),
        .i_reg_offset   (s_axis_tdata[11:0]),
        .i_access_bytes (s_axis_tdata[15:12]),
        .i_write_data   (s_axis_tdata[47:16]),
        .o_result       (w_result)
    );

    vbmr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    // struct already packs read_data lowest; pad up to whole bytes
    assign m_axis_tdata = {{(TDATA_OUT_W - RESULT_W){1'b0}}, w_out};

endmodule

`default_nettype wire
